[hdl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Every macro samples on posedge clk; CHK_SAME and CHK_NEXT are disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that holds also while reset is high
`define CHK_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/tmq_pkg.sv]
// Package for the typed message queue: codes, control structs, defaults.
// No dependencies; used by the cell, the top level, the checkers and the testbench.
package tmq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 16;

  localparam logic [4:0]  COUNT_LIMIT_RST = 5'd16;
  localparam logic [19:0] BYTE_LIMIT_RST  = 20'd16384;
  localparam logic [15:0] MAX_MSG_RST     = 16'd8192;

  typedef enum logic [1:0] {
    REQ_SEND  = 2'd0,
    REQ_RECV  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOMSG   = 3'd3,
    ST_TOOBIG  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_COUNT_LIMIT = 2'd0,
    REG_BYTE_LIMIT  = 2'd1,
    REG_MAX_MSG     = 2'd2
  } reg_index_t;

  // Receive selector kinds
  typedef enum logic [1:0] {
    SEL_OLDEST = 2'd0,
    SEL_EXACT  = 2'd1,
    SEL_BELOW  = 2'd2
  } sel_mode_t;

  // Per-cell update command
  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

[hdl/tmq_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; field widths are fixed by the queue's word format.
interface tmq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] type_value;
  logic [15:0]        length;
  logic [15:0]        payload_handle;
  logic               no_error;

  modport source (output valid, req_type, type_value, length, payload_handle, no_error,
                  input ready);
  modport sink (input valid, req_type, type_value, length, payload_handle, no_error,
                output ready);
endinterface

interface tmq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [30:0] out_type;
  logic [15:0] out_handle;
  logic [15:0] out_length;
  logic [4:0]  count_now;
  logic [19:0] bytes_now;

  modport source (output valid, status, out_type, out_handle, out_length, count_now,
                  bytes_now, input ready);
  modport sink (input valid, status, out_type, out_handle, out_length, count_now,
                bytes_now, output ready);
endinterface

[hdl/tmq_cell.sv]
// One queue slot: holds a descriptor, shifts from its younger neighbor and
// forwards a registered search token. Depends on tmq_pkg.
module tmq_cell #(
  parameter int IDX         = 0,
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 16,
  localparam int IW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tmq_pkg::cell_ctl_t     ctl,
  input  tmq_pkg::sel_mode_t     mode,
  input  logic [31:0]            sel_key,
  input  logic [30:0]            new_type,
  input  logic [15:0]            new_len,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic [30:0]            nxt_type,
  input  logic [15:0]            nxt_len,
  input  logic [HANDLE_BITS-1:0] nxt_handle,
  input  logic                   nxt_valid,
  input  logic                   tin_found,
  input  logic [IW-1:0]          tin_idx,
  input  logic [30:0]            tin_type,
  input  logic [15:0]            tin_len,
  input  logic [HANDLE_BITS-1:0] tin_handle,
  output logic [30:0]            ent_type,
  output logic [15:0]            ent_len,
  output logic [HANDLE_BITS-1:0] ent_handle,
  output logic                   ent_valid,
  output logic                   tout_found,
  output logic [IW-1:0]          tout_idx,
  output logic [30:0]            tout_type,
  output logic [15:0]            tout_len,
  output logic [HANDLE_BITS-1:0] tout_handle
);
  import tmq_pkg::*;

  logic hit;

  // Valid bit: clear on flush, set on load, take neighbor's on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (ctl.clear) begin
      ent_valid <= 1'b0;
    end else if (ctl.load) begin
      ent_valid <= 1'b1;
    end else if (ctl.shift) begin
      ent_valid <= nxt_valid;
    end
  end

  // Descriptor payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent_type   <= new_type;
      ent_len    <= new_len;
      ent_handle <= new_handle;
    end else if (ctl.shift) begin
      ent_type   <= nxt_type;
      ent_len    <= nxt_len;
      ent_handle <= nxt_handle;
    end
  end

  // Decide whether this slot beats the token coming from older slots
  always_comb begin
    case (mode)
      SEL_OLDEST: hit = ent_valid && !tin_found;
      SEL_EXACT:  hit = ent_valid && !tin_found && ({1'b0, ent_type} == sel_key);
      SEL_BELOW:  hit = ent_valid && ({1'b0, ent_type} <= sel_key) &&
                        (!tin_found || (ent_type < tin_type));
      default:    hit = 1'b0;
    endcase
  end

  // Pass the token on, one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tout_found <= 1'b0;
    end else begin
      tout_found <= tin_found || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      tout_idx    <= IW'(IDX);
      tout_type   <= ent_type;
      tout_len    <= ent_len;
      tout_handle <= ent_handle;
    end else begin
      tout_idx    <= tin_idx;
      tout_type   <= tin_type;
      tout_len    <= tin_len;
      tout_handle <= tin_handle;
    end
  end

endmodule

[hdl/typed_message_queue.sv]
// Typed message queue top level: request/response channels, APB registers,
// sequencer and the row of tmq_cell slots. Depends on tmq_pkg and tmq_if.
//
// Usage:
//   req carries one request word: send (append a descriptor), receive
//   (remove one chosen by a signed type selector) or flush. rsp returns
//   exactly one word per request with status and occupancy after it.
//   Registers count_limit (0x0), byte_limit (0x4) and max_message_bytes
//   (0x8): user writes them over APB while the queue is idle; not enforced.
// Timing:
//   One request at a time. Send and flush go from accept to S_EXEC; a receive
//   first passes S_SCAN while the search token walks the DEPTH cells one cell
//   per clock, then S_EXEC commits once the response register is free.
//   req.ready returns in the same cycle the response word appears.
// Reset:
//   rst empties the queue, restores register defaults (16, 16384, 8192).
// Stall:
//   The response sits in an output register; while rsp.ready is low the
//   next request is still accepted and searched, and waits to commit until
//   the response register frees.
module typed_message_queue #(
  parameter int DEPTH       = tmq_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = tmq_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tmq_req_if.sink     req,
  tmq_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  logic [4:0]  count_limit;
  logic [19:0] byte_limit;
  logic [15:0] max_message_bytes;

  logic [1:0]         r_req;
  logic signed [31:0] r_type;
  logic [15:0]        r_len;
  logic [15:0]        r_handle;
  logic               r_noerr;

  logic [CW-1:0] held_count, held_count_next;
  logic [19:0]   held_bytes, held_bytes_next;
  logic [CW-1:0] scan_cnt;

  logic               go;
  logic               send_ok, recv_ok;
  logic [6:0]         lim;
  logic [20:0]        bytes_sum;
  sel_mode_t          mode;
  logic [31:0]        sel_key;
  status_t            st_n;
  logic [30:0]        otype_n;
  logic [15:0]        ohandle_n, olen_n;

  logic [30:0]            ent_type   [DEPTH];
  logic [15:0]            ent_len    [DEPTH];
  logic [HANDLE_BITS-1:0] ent_handle [DEPTH];
  logic                   ent_valid  [DEPTH];
  logic                   tok_found  [DEPTH+1];
  logic [IW-1:0]          tok_idx    [DEPTH+1];
  logic [30:0]            tok_type   [DEPTH+1];
  logic [15:0]            tok_len    [DEPTH+1];
  logic [HANDLE_BITS-1:0] tok_handle [DEPTH+1];
  cell_ctl_t              ctl        [DEPTH];

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit       <= COUNT_LIMIT_RST;
      byte_limit        <= BYTE_LIMIT_RST;
      max_message_bytes <= MAX_MSG_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_COUNT_LIMIT: count_limit       <= pwdata[4:0];
        REG_BYTE_LIMIT:  byte_limit        <= pwdata[19:0];
        REG_MAX_MSG:     max_message_bytes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COUNT_LIMIT: prdata = {27'd0, count_limit};
      REG_BYTE_LIMIT:  prdata = {12'd0, byte_limit};
      REG_MAX_MSG:     prdata = {16'd0, max_message_bytes};
      default:         prdata = 32'd0;
    endcase
  end

  // Capture the request word
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      r_req    <= req.req_type;
      r_type   <= req.type_value;
      r_len    <= req.length;
      r_handle <= req.payload_handle;
      r_noerr  <= req.no_error;
    end
  end

  // Selector decode
  always_comb begin
    if (r_type == 32'sd0) begin
      mode    = SEL_OLDEST;
      sel_key = 32'd0;
    end else if (r_type > 32'sd0) begin
      mode    = SEL_EXACT;
      sel_key = r_type;
    end else begin
      mode    = SEL_BELOW;
      sel_key = 32'd0 - r_type;
    end
  end

  // Sequencer
  assign go = (state == S_EXEC) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.req_type == REQ_RECV) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_cnt == CW'(DEPTH - 1)) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Request outcome
  assign lim       = (7'(count_limit) < 7'(DEPTH)) ? 7'(count_limit) : 7'(DEPTH);
  assign bytes_sum = {1'b0, held_bytes} + 21'(r_len);

  always_comb begin
    st_n            = ST_OK;
    otype_n         = '0;
    ohandle_n       = '0;
    olen_n          = '0;
    send_ok         = 1'b0;
    recv_ok         = 1'b0;
    held_count_next = held_count;
    held_bytes_next = held_bytes;
    case (r_req)
      REQ_SEND: begin
        if (r_type < 32'sd1 || r_len > max_message_bytes) begin
          st_n = ST_INVALID;
        end else if (7'(held_count) >= lim || bytes_sum > 21'(byte_limit)) begin
          st_n = ST_FULL;
        end else begin
          send_ok         = 1'b1;
          held_count_next = held_count + 1'b1;
          held_bytes_next = bytes_sum[19:0];
        end
      end
      REQ_RECV: begin
        if (!tok_found[DEPTH]) begin
          st_n = ST_NOMSG;
        end else if (tok_len[DEPTH] > r_len && !r_noerr) begin
          st_n = ST_TOOBIG;
        end else begin
          recv_ok         = 1'b1;
          otype_n         = tok_type[DEPTH];
          ohandle_n       = 16'(tok_handle[DEPTH]);
          olen_n          = (tok_len[DEPTH] > r_len) ? r_len : tok_len[DEPTH];
          held_count_next = held_count - 1'b1;
          held_bytes_next = held_bytes - 20'(tok_len[DEPTH]);
        end
      end
      REQ_FLUSH: begin
        held_count_next = '0;
        held_bytes_next = '0;
      end
      default: st_n = ST_INVALID;
    endcase
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      held_bytes <= '0;
    end else if (go) begin
      held_count <= held_count_next;
      held_bytes <= held_bytes_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.status     <= st_n;
      rsp.out_type   <= otype_n;
      rsp.out_handle <= ohandle_n;
      rsp.out_length <= olen_n;
      rsp.count_now  <= 5'(held_count_next);
      rsp.bytes_now  <= held_bytes_next;
    end
  end

  // Token enters the oldest slot empty
  assign tok_found[0]  = 1'b0;
  assign tok_idx[0]    = '0;
  assign tok_type[0]   = '0;
  assign tok_len[0]    = '0;
  assign tok_handle[0] = '0;

  // Row of slots, oldest at index 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [30:0]            nt;
    logic [15:0]            nl;
    logic [HANDLE_BITS-1:0] nh;
    logic                   nv;

    if (k == DEPTH - 1) begin : g_last
      assign nt = '0;
      assign nl = '0;
      assign nh = '0;
      assign nv = 1'b0;
    end else begin : g_mid
      assign nt = ent_type[k+1];
      assign nl = ent_len[k+1];
      assign nh = ent_handle[k+1];
      assign nv = ent_valid[k+1];
    end

    assign ctl[k].clear = go && (r_req == REQ_FLUSH);
    assign ctl[k].load  = go && send_ok && (held_count == CW'(k));
    assign ctl[k].shift = go && recv_ok && (IW'(k) >= tok_idx[DEPTH]);

    tmq_cell #(
      .IDX         (k),
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[k]),
      .mode        (mode),
      .sel_key     (sel_key),
      .new_type    (r_type[30:0]),
      .new_len     (r_len),
      .new_handle  (HANDLE_BITS'(r_handle)),
      .nxt_type    (nt),
      .nxt_len     (nl),
      .nxt_handle  (nh),
      .nxt_valid   (nv),
      .tin_found   (tok_found[k]),
      .tin_idx     (tok_idx[k]),
      .tin_type    (tok_type[k]),
      .tin_len     (tok_len[k]),
      .tin_handle  (tok_handle[k]),
      .ent_type    (ent_type[k]),
      .ent_len     (ent_len[k]),
      .ent_handle  (ent_handle[k]),
      .ent_valid   (ent_valid[k]),
      .tout_found  (tok_found[k+1]),
      .tout_idx    (tok_idx[k+1]),
      .tout_type   (tok_type[k+1]),
      .tout_len    (tok_len[k+1]),
      .tout_handle (tok_handle[k+1])
    );
  end

endmodule

[hdl/tmq_checker.sv]
// Port-level checks for the typed message queue, bound to the top level.
// Depends on tmq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmq_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [30:0] out_type,
  input logic [15:0] out_handle,
  input logic [15:0] out_length,
  input logic [4:0]  count_now
);
  import tmq_pkg::*;

  // One request in flight: no accept right after an accept
  `CHK_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request accepted while busy")

  // A failed request reports no message fields
  `CHK_SAME(a_zero_fields, out_valid && status != ST_OK,
            out_type == '0 && out_handle == '0 && out_length == '0, "fields set on failure")

  // Occupancy never exceeds the default number of slots (DEPTH_DEF)
  `CHK_SAME(a_count_range, out_valid, count_now <= 5'(DEPTH_DEF), "count out of range")

  // Response valid, status and count hold under stall
  `CHK_NEXT(a_hold, out_valid && !out_ready,
            out_valid && $stable(status) && $stable(count_now), "response changed under stall")

  // No response the cycle after reset
  `CHK_ALWAYS(a_rst_idle, $past(rst), !out_valid, "response valid after reset")

endmodule

bind typed_message_queue tmq_port_checker u_tmq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .status     (rsp.status),
  .out_type   (rsp.out_type),
  .out_handle (rsp.out_handle),
  .out_length (rsp.out_length),
  .count_now  (rsp.count_now)
);

[dv/tmq_checker.sv]
// Checker for the typed message queue: watches the request, response and APB
// ports, predicts every response word and compares it. Depends on tmq_pkg, tmq_if.
module tmq_checker (
  input  logic        clk,
  input  logic        rst,
  tmq_req_if          req,
  tmq_rsp_if          rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          waiting,
  output int          recv_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct {
    logic [30:0] mtype;
    logic [15:0] mlen;
    logic [15:0] mhandle;
  } mail_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] out_type;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [4:0]  count_now;
    logic [19:0] bytes_now;
  } answer_t;

  mail_t       mailbox[$];
  answer_t     answers[$];
  logic [19:0] held_bytes;
  logic [4:0]  lim_count;
  logic [19:0] lim_bytes;
  logic [15:0] lim_msg;

  // Work out the response word for one request and update the held mailbox
  function automatic answer_t serve(logic [1:0] rt, logic signed [31:0] tv,
                                    logic [15:0] len, logic [15:0] hnd, logic ne);
    answer_t a;
    longint sel;
    int pick;
    int eff;
    mail_t m;
    a = '{default: '0};
    sel = longint'(tv);
    pick = -1;
    eff = (lim_count < DEPTH) ? int'(lim_count) : DEPTH;
    case (rt)
      REQ_SEND: begin
        if (sel < 1 || len > lim_msg) a.status = ST_INVALID;
        else if (mailbox.size() >= eff ||
                 longint'(held_bytes) + longint'(len) > longint'(lim_bytes))
          a.status = ST_FULL;
        else begin
          m.mtype = tv[30:0];
          m.mlen = len;
          m.mhandle = hnd;
          mailbox.push_back(m);
          held_bytes = held_bytes + len;
        end
      end
      REQ_RECV: begin
        // search oldest first; a negative selector keeps the lowest type
        for (int i = 0; i < mailbox.size(); i++) begin
          if (pick < 0 || sel < 0) begin
            if (sel == 0 && pick < 0) pick = i;
            else if (sel > 0 && pick < 0 && longint'(mailbox[i].mtype) == sel) pick = i;
            else if (sel < 0 && longint'(mailbox[i].mtype) <= -sel &&
                     (pick < 0 || mailbox[i].mtype < mailbox[pick].mtype)) pick = i;
          end
        end
        if (pick < 0) a.status = ST_NOMSG;
        else if (mailbox[pick].mlen > len && !ne) a.status = ST_TOOBIG;
        else begin
          a.out_type = mailbox[pick].mtype;
          a.out_handle = mailbox[pick].mhandle;
          a.out_length = (mailbox[pick].mlen > len) ? len : mailbox[pick].mlen;
          held_bytes = held_bytes - mailbox[pick].mlen;
          mailbox.delete(pick);
        end
      end
      REQ_FLUSH: begin
        mailbox.delete();
        held_bytes = '0;
      end
      default: a.status = ST_INVALID;
    endcase
    a.count_now = 5'(mailbox.size());
    a.bytes_now = held_bytes;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t exp_word;
    answer_t got;
    if (rst) begin
      mailbox.delete();
      answers.delete();
      held_bytes = '0;
      lim_count = COUNT_LIMIT_RST;
      lim_bytes = BYTE_LIMIT_RST;
      lim_msg = MAX_MSG_RST;
      fail_count = 0;
      recv_hits = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_COUNT_LIMIT: lim_count = pwdata[4:0];
          REG_BYTE_LIMIT:  lim_bytes = pwdata[19:0];
          REG_MAX_MSG:     lim_msg = pwdata[15:0];
          default: ;
        endcase
      end
      // compare a delivered word with the oldest expectation
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.out_type, rsp.out_handle, rsp.out_length,
                rsp.count_now, rsp.bytes_now};
        if (answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: response word with none expected", $realtime);
        end else begin
          exp_word = answers.pop_front();
          if (got != exp_word) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp st=%0d ty=%0d h=%0d len=%0d cnt=%0d by=%0d",
                       $realtime, exp_word.status, exp_word.out_type, exp_word.out_handle,
                       exp_word.out_length, exp_word.count_now, exp_word.bytes_now,
                       "\n           got st=%0d ty=%0d h=%0d len=%0d cnt=%0d by=%0d",
                       got.status, got.out_type, got.out_handle, got.out_length,
                       got.count_now, got.bytes_now);
          end else if (got.status == ST_OK && got.out_type != 0) begin
            recv_hits++;
          end
        end
      end
      // predict for an accepted request
      if (req.valid && req.ready)
        answers.push_back(serve(req.req_type, req.type_value, req.length,
                                req.payload_handle, req.no_error));
    end
    waiting = answers.size();
  end
endmodule

[dv/tb_typed_message_queue.sv]
// Testbench top for typed_message_queue: clock, reset, request stimulus, APB register
// phases and verdict. Depends on typed_message_queue, tmq_pkg, tmq_if and tmq_checker.
module tb_typed_message_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import tmq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_WORDS = 310;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, waiting, recv_hits;
  bit          calm = 1'b0;
  int          words_sent = 0, reg_writes = 0, quiet = 0, rsp_hold = 0;

  tmq_req_if req_ch ();
  tmq_rsp_if rsp_ch ();

  typed_message_queue dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tmq_checker chk (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .waiting(waiting), .recv_hits(recv_hits)
  );

  always #10 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_SEND;
    req_ch.type_value = '0;
    req_ch.length = '0;
    req_ch.payload_handle = '0;
    req_ch.no_error = 1'b0;
    rsp_ch.ready = 1'b1;
  end

  // Stall the response side in random bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_hold > 0) begin
        rsp_hold--;
        if (rsp_hold == 0) rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 12) == 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold = $urandom_range(1, 18);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive one request word and hold it until accepted, then maybe gap
  task automatic push_word(logic [1:0] rt, logic [31:0] tv, logic [15:0] len,
                           logic [15:0] hnd, logic ne);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.type_value <= tv;
    req_ch.length <= len;
    req_ch.payload_handle <= hnd;
    req_ch.no_error <= ne;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    words_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DEPTH_DEF + 6) @(posedge clk);
  endtask

  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  // One random word: mostly small types and sizes so selectors find matches
  task automatic random_word();
    int r;
    logic [31:0] tv;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      case ($urandom_range(0, 19))
        0: tv = $urandom;
        1: tv = -$urandom_range(0, 3);
        default: tv = $urandom_range(1, 6);
      endcase
      len = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      push_word(REQ_SEND, tv, len, 16'($urandom), 1'($urandom));
    end else if (r < 95) begin
      case ($urandom_range(0, 19))
        0, 1: tv = $urandom;
        2, 3, 4, 5, 6, 7: tv = 0;
        8, 9, 10, 11, 12: tv = -$urandom_range(1, 6);
        default: tv = $urandom_range(1, 6);
      endcase
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      push_word(REQ_RECV, tv, len, 16'($urandom), 1'($urandom));
    end else if (r < 98) begin
      push_word(REQ_FLUSH, $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
    end else begin
      push_word(REQ_UNUSED, $urandom, 16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [4:0]  cfg_count[6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16};
    logic [19:0] cfg_bytes[6] = '{20'd16384, 20'hFFFFF, 20'd1000, 20'd500, 20'd0, 20'hFFFFF};
    logic [15:0] cfg_msg[6] = '{16'd8192, 16'hFFFF, 16'd0, 16'd300, 16'hFFFF, 16'hFFFF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: bad sends, extremes, each selector kind, oversize, flush, unused code
    push_word(REQ_SEND, 32'd0, 16'd10, 16'h0001, 1'b0);
    push_word(REQ_SEND, 32'hFFFF_FFFF, 16'd10, 16'h0002, 1'b0);
    push_word(REQ_SEND, 32'd3, 16'd8193, 16'h0003, 1'b0);
    push_word(REQ_RECV, 32'd0, 16'd100, 16'h0, 1'b0);
    push_word(REQ_SEND, 32'h7FFF_FFFF, 16'd8192, 16'hFFFF, 1'b0);
    push_word(REQ_SEND, 32'd5, 16'd40, 16'hA5A5, 1'b0);
    push_word(REQ_SEND, 32'd2, 16'd0, 16'h5A5A, 1'b0);
    push_word(REQ_SEND, 32'd5, 16'd20, 16'h1234, 1'b0);
    push_word(REQ_SEND, 32'd1, 16'd8192, 16'h0, 1'b0);
    push_word(REQ_RECV, 32'd9, 16'd100, 16'h0, 1'b0);
    push_word(REQ_RECV, 32'd5, 16'd10, 16'h0, 1'b0);
    push_word(REQ_RECV, 32'd5, 16'd10, 16'h0, 1'b1);
    push_word(REQ_RECV, -32'sd4, 16'd100, 16'h0, 1'b0);
    push_word(REQ_RECV, 32'h8000_0000, 16'hFFFF, 16'h0, 1'b0);
    push_word(REQ_RECV, 32'h8000_0001, 16'd0, 16'h0, 1'b1);
    push_word(REQ_RECV, 32'd0, 16'hFFFF, 16'h0, 1'b0);
    push_word(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_word(REQ_SEND, 32'd7, 16'd1, 16'h0F0F, 1'b0);
    push_word(REQ_FLUSH, 32'd0, 16'd0, 16'h0, 1'b0);
    push_word(REQ_RECV, 32'd0, 16'd0, 16'h0, 1'b0);

    // phases with different limits; limits change while words remain held
    for (int p = 0; p < 6; p++) begin
      drain();
      calm = (p == 5);
      reg_write(REG_COUNT_LIMIT, 32'(cfg_count[p]));
      reg_write(REG_BYTE_LIMIT, 32'(cfg_bytes[p]));
      reg_write(REG_MAX_MSG, 32'(cfg_msg[p]));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 1 && n == PHASE_WORDS / 2) drain();
        random_word();
      end
    end

    drain();
    $display("covered %0d request words over %0d register writes (six limit settings)",
             words_sent, reg_writes);
    $display("%0d receives delivered a message", recv_hits);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[files.f]
+incdir+hdl
hdl/tmq_pkg.sv
hdl/tmq_if.sv
hdl/tmq_cell.sv
hdl/typed_message_queue.sv
hdl/tmq_checker.sv
dv/tmq_checker.sv
dv/tb_typed_message_queue.sv
